/* rtl/joint_intensity_label_histogram_defines.svh */
// Assertion macros shared by the histogram RTL.
`ifndef JOINT_INTENSITY_LABEL_HISTOGRAM_DEFINES_SVH
`define JOINT_INTENSITY_LABEL_HISTOGRAM_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define JILH_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define JILH_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

/* rtl/jilh_pkg.sv */
// Package with constants, types and helpers of the joint histogram block.
package jilh_pkg;
   localparam int MAX_BINS = 64;
   localparam int MAX_LABELS = 16;
   localparam int COUNT_BITS = 32;
   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int LAB_W = $clog2(MAX_LABELS);
   localparam int JNT_W = BIN_W + LAB_W;
   localparam int DEN_W = COUNT_BITS + 17;
   localparam int NUM_W = COUNT_BITS + 16;

   localparam logic [1:0] CMD_ACC = 2'd0;
   localparam logic [1:0] CMD_QRY = 2'd1;
   localparam logic [1:0] CMD_CLR = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] REG_RANGE = 2'd0;
   localparam logic [1:0] REG_BINS = 2'd1;
   localparam logic [1:0] REG_LABELS = 2'd2;
   localparam logic [1:0] REG_ALPHA = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_BINDIV, ST_RMW_RD, ST_RMW_WR, ST_Q_RD, ST_Q_MUL,
      ST_Q_DIV, ST_Q_OUT
   } state_type;

   // Divider handshake between the top level and the divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

/* rtl/jilh_divider.sv */
// Restoring divider: floor(num * 2^16 / den) saturated to 16 bits.
module jilh_divider
   import jilh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_ctl_type        ctl,
   output logic [15:0]        quot
);
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [15:0]      q_ff, q_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   sh;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = {rem_ff[DEN_W-1:0], 1'b0};
      if (start) begin
         den_in = den;
         rem_in = {{(DEN_W + 1 - NUM_W){1'b0}}, num};
         q_in = '0;
         cnt_in = 5'd0;
         if (DEN_W'(num) >= den) begin
            q_in = 16'hFFFF;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         q_in = {q_ff[14:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            rem_in = sh - {1'b0, den_ff};
            q_in[0] = 1'b1;
         end else begin
            rem_in = sh;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign quot = q_ff;
endmodule

/* rtl/joint_intensity_label_histogram.sv */
// Top level of the joint intensity/label histogram estimator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    cmd, intensity, label, flags, query
//   rsp      out        rsp_valid/rsp_ready    four Q0.16 probabilities, status
//   csr      in         csr_write_enable       csr_index, csr_data
//
// An accumulate word takes the bin index from a 16-step restoring division
// of intensity*bins by range, then one memory read and one write-back of the
// joint, label and bin counters. A pixel at or above the range skips the
// division. A query word runs four divisions on one shared unit, fewer when
// a divisor is zero. After reset and on a clear word a sweep over all 1024
// joint addresses zeroes the memories. A finished response moves into an
// output register; a stalled rsp side holds it, and only a second finished
// query waits for it to leave, which then stalls req.
module joint_intensity_label_histogram
   import jilh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_intensity,
   input  logic [3:0]  req_label,
   input  logic        req_skip_sample,
   input  logic [5:0]  req_query_bin,
   input  logic [3:0]  req_query_label,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_prob_label,
   output logic [15:0] rsp_prob_bin,
   output logic [15:0] rsp_prob_label_given_bin,
   output logic [15:0] rsp_prob_bin_given_label,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
`include "joint_intensity_label_histogram_defines.svh"

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Configuration registers.
   logic [15:0] range_ff;
   logic [6:0]  bins_ff;
   logic [4:0]  labels_ff;
   logic [15:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 16'd1380;
         bins_ff <= 7'd64;
         labels_ff <= 5'd16;
         alpha_ff <= 16'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RANGE:  range_ff <= csr_data;
            REG_BINS:   bins_ff <= csr_data[6:0];
            REG_LABELS: labels_ff <= csr_data[4:0];
            REG_ALPHA:  alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective counts clamped into the supported range.
   logic [6:0] nb;
   logic [4:0] nl;
   always_comb begin
      nb = bins_ff;
      if (nb == 7'd0) nb = 7'd1;
      if (nb > 7'(MAX_BINS)) nb = 7'(MAX_BINS);
      nl = labels_ff;
      if (nl == 5'd0) nl = 5'd1;
      if (nl > 5'(MAX_LABELS)) nl = 5'(MAX_LABELS);
   end

   // Counter memories, each with a registered read port.
   logic [COUNT_BITS-1:0] joint_mem [MAX_BINS*MAX_LABELS];
   logic [COUNT_BITS-1:0] bin_mem [MAX_BINS];
   logic [COUNT_BITS-1:0] lab_mem [MAX_LABELS];
   logic [COUNT_BITS-1:0] jrd_ff, brd_ff, lrd_ff, total_ff, total_in;
   logic [JNT_W-1:0] ja;
   logic [BIN_W-1:0] ba;
   logic [LAB_W-1:0] la;
   logic             we;
   logic [COUNT_BITS-1:0] jwd, bwd, lwd;

   always_ff @(posedge clock) begin
      if (we) begin
         joint_mem[ja] <= jwd;
         bin_mem[ba] <= bwd;
         lab_mem[la] <= lwd;
      end
      jrd_ff <= joint_mem[ja];
      brd_ff <= bin_mem[ba];
      lrd_ff <= lab_mem[la];
   end

   state_type st_ff, st_in;
   logic [JNT_W:0] clr_ff, clr_in;
   logic [15:0] int_ff, int_in;
   logic [LAB_W-1:0] lab_ff, lab_in;
   logic [BIN_W-1:0] bin_ff, bin_in;
   logic        inr_ff, inr_in;
   logic [1:0]  dsel_ff, dsel_in;
   logic [COUNT_BITS+15:0] at_ff, at_in;
   logic [15:0] pl_ff, pl_in, pb_ff, pb_in, plb_ff, plb_in, pbl_ff, pbl_in;
   logic        sts_ff, sts_in, ov_ff, ov_in;
   // Output register: the four probabilities and the status of the response.
   logic [64:0] out_ff, out_in;

   // Shared divider.
   logic              dstart;
   logic [NUM_W-1:0]  dnum;
   logic [DEN_W-1:0]  dden;
   div_ctl_type       dctl;
   logic [15:0]       dq;

   jilh_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .ctl(dctl), .quot(dq)
   );

   logic [COUNT_BITS-1:0] lc, bc, jc;
   assign lc = inr_ff ? lrd_ff : '0;
   assign bc = inr_ff ? brd_ff : '0;
   assign jc = inr_ff ? jrd_ff : '0;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   // Divider operand for the bin index: intensity*nb is divided by
   // range*64, which gives floor(intensity*nb*1024/range).
   logic [22:0] inb;
   assign inb = int_ff * nb;

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      int_in = int_ff;
      lab_in = lab_ff;
      bin_in = bin_ff;
      inr_in = inr_ff;
      dsel_in = dsel_ff;
      at_in = at_ff;
      pl_in = pl_ff;
      pb_in = pb_ff;
      plb_in = plb_ff;
      pbl_in = pbl_ff;
      sts_in = sts_ff;
      ov_in = ov_ff;
      out_in = out_ff;
      total_in = total_ff;
      we = 1'b0;
      ja = {lab_ff, bin_ff};
      ba = bin_ff;
      la = lab_ff;
      jwd = sat_inc(jrd_ff);
      bwd = sat_inc(brd_ff);
      lwd = sat_inc(lrd_ff);
      dstart = 1'b0;
      dnum = '0;
      dden = '0;
      req_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            we = 1'b1;
            ja = clr_ff[JNT_W-1:0];
            ba = clr_ff[BIN_W-1:0];
            la = clr_ff[LAB_W-1:0];
            jwd = '0;
            bwd = '0;
            lwd = '0;
            total_in = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (JNT_W+1)'(MAX_BINS*MAX_LABELS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               int_in = req_intensity;
               case (req_cmd)
                  CMD_ACC: begin
                     lab_in = req_label;
                     if (!req_skip_sample && {1'b0, req_label} < nl) begin
                        if (req_intensity >= range_ff) begin
                           bin_in = BIN_W'(nb - 7'd1);
                           st_in = ST_RMW_RD;
                        end else begin
                           st_in = ST_BINDIV;
                           dsel_in = 2'd0;
                        end
                     end
                  end
                  CMD_QRY: begin
                     lab_in = req_query_label;
                     bin_in = req_query_bin;
                     inr_in = ({1'b0, req_query_bin} < nb) &&
                              ({1'b0, req_query_label} < nl);
                     st_in = ST_Q_RD;
                  end
                  CMD_CLR: begin
                     clr_in = '0;
                     st_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_BINDIV: begin
            // floor(x/r) for x < 64*r: the divider on x against r*64 gives
            // floor(x*1024/r), so its top six quotient bits are the bin.
            if (!dctl.busy && !dctl.done && dsel_ff == 2'd0) begin
               dstart = 1'b1;
               dnum = NUM_W'(inb);
               dden = DEN_W'({range_ff, 6'd0});
               dsel_in = 2'd1;
            end
            if (dctl.done) begin
               // quotient = floor(x*2^16/(r*64)) ; bin = quotient >> 10
               bin_in = (dq[15:10] >= nb[5:0] && nb != 7'd64) ?
                        BIN_W'(nb - 7'd1) : dq[15:10];
               st_in = ST_RMW_RD;
            end
         end
         ST_RMW_RD: st_in = ST_RMW_WR;
         ST_RMW_WR: begin
            we = 1'b1;
            total_in = sat_inc(total_ff);
            st_in = ST_IDLE;
         end
         ST_Q_RD: st_in = ST_Q_MUL;
         ST_Q_MUL: begin
            at_in = alpha_ff * total_ff;
            sts_in = (total_ff == '0) || (bc == '0);
            pl_in = '0;
            pb_in = '0;
            plb_in = '0;
            pbl_in = '0;
            dsel_in = 2'd0;
            st_in = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (!dctl.busy && !dctl.done) begin
               case (dsel_ff)
                  2'd0: begin
                     dstart = total_ff != '0;
                     dnum = NUM_W'(lc);
                     dden = DEN_W'(total_ff);
                     if (total_ff == '0) dsel_in = 2'd2;
                  end
                  2'd1: begin
                     dstart = 1'b1;
                     dnum = NUM_W'(bc);
                     dden = DEN_W'(total_ff);
                  end
                  2'd2: begin
                     dstart = bc != '0;
                     dnum = NUM_W'(jc);
                     dden = DEN_W'(bc);
                     if (bc == '0) dsel_in = 2'd3;
                  end
                  default: begin
                     dden = DEN_W'({lc, 16'd0}) + DEN_W'(at_ff);
                     dnum = {jc, 16'd0};
                     dstart = dden != '0;
                     if (dden == '0) begin
                        sts_in = 1'b1;
                        st_in = ST_Q_OUT;
                     end
                  end
               endcase
            end
            if (dctl.done) begin
               case (dsel_ff)
                  2'd0: pl_in = dq;
                  2'd1: pb_in = dq;
                  2'd2: plb_in = dq;
                  default: pbl_in = dq;
               endcase
               dsel_in = dsel_ff + 2'd1;
               if (dsel_ff == 2'd3) st_in = ST_Q_OUT;
            end
         end
         ST_Q_OUT: begin
            // The result moves out once the output register is free or
            // being emptied in this cycle.
            if (!ov_ff || rsp_ready) begin
               out_in = {pl_ff, pb_ff, plb_ff, pbl_ff, sts_ff};
               ov_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // The divider computes floor(n*2^16/d); the first-quotient-word
   // division for pl/pb is a full Q16 divide of lc or bc by total.
   // For the joint/label term the numerator already holds jc*2^16, and
   // the divider adds another 2^16: matching jc*2^32/(lc*2^16+a*t).

   always_ff @(posedge clock) begin
      int_ff <= int_in;
      lab_ff <= lab_in;
      bin_ff <= bin_in;
      inr_ff <= inr_in;
      dsel_ff <= dsel_in;
      at_ff <= at_in;
      pl_ff <= pl_in;
      pb_ff <= pb_in;
      plb_ff <= plb_in;
      pbl_ff <= pbl_in;
      sts_ff <= sts_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         ov_ff <= ov_in;
         total_ff <= total_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_prob_label = out_ff[64:49];
   assign rsp_prob_bin = out_ff[48:33];
   assign rsp_prob_label_given_bin = out_ff[32:17];
   assign rsp_prob_bin_given_label = out_ff[16:1];
   assign rsp_status = out_ff[0];

   `JILH_ASSERT_IMP(a_no_accept_busy, clock, reset, req_ready, st_ff == ST_IDLE)
   `JILH_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `JILH_ASSERT_IMP(a_div_one_start, clock, reset, dstart, !dctl.busy)
endmodule
